// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
// clocked on i_clk, the second form stays active during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define MFI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define MFI_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`endif

// ===== hw/rtl/mfi_pkg.sv =====
// shared types, constants and helper functions of the mlp inference block
// no dependencies
package mfi_pkg;

    localparam int unsigned MAX_WEIGHT_LAYERS_DEF = 4;
    localparam int unsigned MAX_NEURONS_DEF       = 16;
    localparam int unsigned VALUE_WIDTH_DEF       = 16;
    localparam int unsigned CMD_QUEUE_DEPTH       = 2;

    localparam int unsigned SIZE_W     = 5;
    localparam int unsigned LCOUNT_W   = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 5;
    localparam int unsigned FIELD_W    = 16;
    localparam int unsigned ACC_W      = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_ACT_KIND     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN_ONE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN_TWO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN_THREE = 3'd5;

    localparam int unsigned SIG_DEPTH = 256;
    localparam int unsigned SIG_W     = 9;
    localparam logic [63:0] EXP_STEP  = 64'd4034748382;

    typedef enum logic {
        ACT_RELU    = 1'b0,
        ACT_SIGMOID = 1'b1
    } t_act;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_ACT
    } t_state;

    typedef struct packed {
        t_act              act_kind;
        logic [LCOUNT_W-1:0] layer_count;
        logic [SIZE_W-1:0] input_size;
        logic [SIZE_W-1:0] hidden_one_size;
        logic [SIZE_W-1:0] hidden_two_size;
        logic [SIZE_W-1:0] hidden_three_size;
    } t_cfg;

    typedef struct packed {
        logic is_weight;
        logic store_feat;
        logic last;
    } t_cmd_ctl;

    typedef logic [SIG_DEPTH-1:0][SIG_W-1:0] t_sig_rom;

    // shift and subtract long division, only used while building constants
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sigmoid table over [-8,8) in steps of 1/16, built at elaboration
    function automatic t_sig_rom gen_sig_rom();
        t_sig_rom     rom;
        logic [63:0]  e;
        logic [63:0]  den;
        logic [127:0] prod;
        rom = '0;
        e   = 64'd1 << 32;
        for (int m = 0; m <= 128; m++) begin
            den = (64'd1 << 32) + e;
            if (m < 128) rom[128 + m] = SIG_W'(udiv64((64'd1 << 40) + (den >> 1), den));
            if (m >= 1) rom[128 - m] = SIG_W'(udiv64((e << 8) + (den >> 1), den));
            prod = 128'(e) * 128'(EXP_STEP);
            e    = 64'((prod + (128'd1 << 31)) >> 32);
        end
        return rom;
    endfunction

    localparam t_sig_rom SIG_ROM = gen_sig_rom();

    // zero acts as one, oversize clamps to the neuron limit
    function automatic logic [8:0] eff_size(input logic [SIZE_W-1:0] r,
                                            input int unsigned max_n);
        logic [8:0] res;
        if (r == '0) res = 9'd1;
        else if (32'(r) > max_n) res = 9'(max_n);
        else res = 9'(r);
        return res;
    endfunction

endpackage

// ===== hw/rtl/mlp_forward_inference.sv =====
// top level of the fixed-point mlp inference block
// depends on mfi_pkg, mfi_front, mfi_cmd_fifo, mfi_back, mfi_ram
//
// usage: an item is taken at a clock edge with i_start high and o_busy low.
// i_kind 0 writes one weight word (layer, row, column); row equal to the
// previous layer size is the bias row. i_kind 1 stores one feature; with
// i_last_feature set it also runs the whole network and gives one result.
// configuration is written through i_cfg_we/i_cfg_addr/i_cfg_wdata; the user
// must do so only while idle, the block itself does not enforce it. a two-entry
// command queue sits between the front end and the sequencer, so items keep
// being taken while a pass runs until the queue is full. weight and plain
// feature items are executed by the sequencer as they are popped while idle;
// a popped last feature item starts a pass, which runs neuron by neuron through
// the single multiply-accumulate unit and the weight ram read port.
// o_valid marks the result for exactly one cycle; the receiver cannot stall.
// reset clears the queue, the sequencer and restores the register defaults;
// weights and features are undefined until written.
module mlp_forward_inference #(
    parameter int unsigned MAX_WEIGHT_LAYERS = mfi_pkg::MAX_WEIGHT_LAYERS_DEF,
    parameter int unsigned MAX_NEURONS       = mfi_pkg::MAX_NEURONS_DEF,
    parameter int unsigned VALUE_WIDTH       = mfi_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic                               i_kind,
    input  logic [1:0]                         i_layer_index,
    input  logic [4:0]                         i_row_index,
    input  logic [3:0]                         i_column_index,
    input  logic signed [15:0]                 i_value,
    input  logic                               i_last_feature,
    input  logic                               i_cfg_we,
    input  logic [mfi_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [mfi_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output logic                               o_valid,
    output logic signed [15:0]                 o_prediction,
    output logic                               o_saturated
);
    import mfi_pkg::*;

    localparam int unsigned STORE_DEPTH = MAX_WEIGHT_LAYERS * (MAX_NEURONS + 1) * MAX_NEURONS;
    localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
    localparam int unsigned NIDX_W = $clog2(MAX_NEURONS);
    localparam int unsigned CNT_W  = $clog2(MAX_NEURONS + 1);
    localparam int unsigned LCNT_W = $clog2(MAX_WEIGHT_LAYERS + 1);
    localparam int unsigned CTL_W  = $bits(t_cmd_ctl);
    localparam int unsigned QW     = CTL_W + ADDR_W + NIDX_W + VALUE_WIDTH;

    t_cfg r_cfg;

    logic                          accept;
    logic                          push;
    t_cmd_ctl                      f_ctl, h_ctl;
    logic [ADDR_W-1:0]             f_addr, h_addr;
    logic [NIDX_W-1:0]             f_fidx, h_fidx;
    logic signed [VALUE_WIDTH-1:0] f_val, h_val;
    logic [QW-1:0]                 q_in, q_head;
    logic                          q_empty, q_full, pop;
    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_raddr;
    logic [VALUE_WIDTH-1:0]        ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.act_kind          <= ACT_RELU;
            r_cfg.layer_count       <= LCOUNT_W'(2);
            r_cfg.input_size        <= SIZE_W'(16);
            r_cfg.hidden_one_size   <= SIZE_W'(16);
            r_cfg.hidden_two_size   <= SIZE_W'(16);
            r_cfg.hidden_three_size <= SIZE_W'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ACT_KIND:     r_cfg.act_kind          <= t_act'(i_cfg_wdata[0]);
                CFG_LAYER_COUNT:  r_cfg.layer_count       <= i_cfg_wdata[LCOUNT_W-1:0];
                CFG_INPUT_SIZE:   r_cfg.input_size        <= i_cfg_wdata;
                CFG_HIDDEN_ONE:   r_cfg.hidden_one_size   <= i_cfg_wdata;
                CFG_HIDDEN_TWO:   r_cfg.hidden_two_size   <= i_cfg_wdata;
                CFG_HIDDEN_THREE: r_cfg.hidden_three_size <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_busy = q_full;
    assign accept = i_start && !q_full;

    mfi_front #(
        .MAX_WEIGHT_LAYERS (MAX_WEIGHT_LAYERS),
        .MAX_NEURONS       (MAX_NEURONS),
        .VALUE_WIDTH       (VALUE_WIDTH),
        .ADDR_W            (ADDR_W),
        .NIDX_W            (NIDX_W)
    ) u_front (
        .i_cfg          (r_cfg),
        .i_accept       (accept),
        .i_kind         (i_kind),
        .i_layer_index  (i_layer_index),
        .i_row_index    (i_row_index),
        .i_column_index (i_column_index),
        .i_value        (i_value),
        .i_last_feature (i_last_feature),
        .o_push         (push),
        .o_ctl          (f_ctl),
        .o_addr         (f_addr),
        .o_fidx         (f_fidx),
        .o_val          (f_val)
    );

    assign q_in = {f_ctl, f_addr, f_fidx, f_val};

    mfi_cmd_fifo #(
        .WIDTH (QW),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign {h_ctl, h_addr, h_fidx, h_val} = q_head;

    mfi_back #(
        .MAX_WEIGHT_LAYERS (MAX_WEIGHT_LAYERS),
        .MAX_NEURONS       (MAX_NEURONS),
        .VALUE_WIDTH       (VALUE_WIDTH),
        .ADDR_W            (ADDR_W),
        .NIDX_W            (NIDX_W),
        .CNT_W             (CNT_W),
        .LCNT_W            (LCNT_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_empty      (q_empty),
        .i_head_ctl   (h_ctl),
        .i_head_fidx  (h_fidx),
        .i_head_val   (h_val),
        .o_pop        (pop),
        .o_ram_we     (ram_we),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata),
        .o_valid      (o_valid),
        .o_prediction (o_prediction),
        .o_saturated  (o_saturated)
    );

    mfi_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_weights (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (h_addr),
        .i_wdata (h_val),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );
endmodule

// ===== hw/rtl/mfi_ram.sv =====
// generic single-port-write ram with registered read
// no dependencies
module mfi_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1088
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/mfi_front.sv =====
// front end: classifies accepted items into queue commands
// depends on mfi_pkg
module mfi_front #(
    parameter int unsigned MAX_WEIGHT_LAYERS = 4,
    parameter int unsigned MAX_NEURONS       = 16,
    parameter int unsigned VALUE_WIDTH       = 16,
    parameter int unsigned ADDR_W            = 11,
    parameter int unsigned NIDX_W            = 4
) (
    input  mfi_pkg::t_cfg                   i_cfg,
    input  logic                            i_accept,
    input  logic                            i_kind,
    input  logic [1:0]                      i_layer_index,
    input  logic [4:0]                      i_row_index,
    input  logic [3:0]                      i_column_index,
    input  logic signed [15:0]              i_value,
    input  logic                            i_last_feature,
    output logic                            o_push,
    output mfi_pkg::t_cmd_ctl               o_ctl,
    output logic [ADDR_W-1:0]               o_addr,
    output logic [NIDX_W-1:0]               o_fidx,
    output logic signed [VALUE_WIDTH-1:0]   o_val
);
    import mfi_pkg::*;

    localparam longint VMAX = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
    localparam longint VMIN = -VMAX - 1;

    logic in_range;
    logic store_feat;

    assign in_range = (32'(i_layer_index) < MAX_WEIGHT_LAYERS)
                   && (32'(i_row_index) <= MAX_NEURONS)
                   && (32'(i_column_index) < MAX_NEURONS);
    assign store_feat = 9'(i_row_index) < eff_size(i_cfg.input_size, MAX_NEURONS);

    always_comb begin
        if (longint'(i_value) > VMAX) o_val = VALUE_WIDTH'(VMAX);
        else if (longint'(i_value) < VMIN) o_val = VALUE_WIDTH'(VMIN);
        else o_val = VALUE_WIDTH'(i_value);
    end

    assign o_addr = ADDR_W'((int'(i_layer_index) * (MAX_NEURONS + 1) + int'(i_row_index))
                            * MAX_NEURONS + int'(i_column_index));
    assign o_fidx = NIDX_W'(i_row_index);

    assign o_ctl.is_weight  = !i_kind;
    assign o_ctl.store_feat = i_kind && store_feat;
    assign o_ctl.last       = i_kind && i_last_feature;

    // dropped weight writes and unstored non-last features never enter the queue
    assign o_push = i_accept && (i_kind ? (store_feat || i_last_feature) : in_range);
endmodule

// ===== hw/rtl/mfi_cmd_fifo.sv =====
// short command queue between the front and back ends
// no dependencies
module mfi_cmd_fifo #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_head,
    output logic             o_empty,
    output logic             o_full
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) r_count <= r_count + 1'b1;
            else if (do_pop && !do_push) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end
endmodule

// ===== hw/rtl/mfi_back.sv =====
// back end: executes queued commands and sequences the layer passes
// depends on mfi_pkg; drives the weight ram read port
module mfi_back #(
    parameter int unsigned MAX_WEIGHT_LAYERS = 4,
    parameter int unsigned MAX_NEURONS       = 16,
    parameter int unsigned VALUE_WIDTH       = 16,
    parameter int unsigned ADDR_W            = 11,
    parameter int unsigned NIDX_W            = 4,
    parameter int unsigned CNT_W             = 5,
    parameter int unsigned LCNT_W            = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mfi_pkg::t_cfg                 i_cfg,
    input  logic                          i_empty,
    input  mfi_pkg::t_cmd_ctl             i_head_ctl,
    input  logic [NIDX_W-1:0]             i_head_fidx,
    input  logic signed [VALUE_WIDTH-1:0] i_head_val,
    output logic                          o_pop,
    output logic                          o_ram_we,
    output logic [ADDR_W-1:0]             o_ram_raddr,
    input  logic signed [VALUE_WIDTH-1:0] i_ram_rdata,
    output logic                          o_valid,
    output logic signed [15:0]            o_prediction,
    output logic                          o_saturated
);
    import mfi_pkg::*;

    localparam int unsigned VW     = VALUE_WIDTH;
    localparam int unsigned PROD_W = 2 * VW;
    localparam longint VMAX = (longint'(1) << (VW - 1)) - 1;
    localparam longint VMIN = -VMAX - 1;
    localparam logic signed [ACC_W:0] ACC_MAX = 65'sh0_3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [ACC_W:0] ACC_MIN = -ACC_MAX;
    localparam logic [ADDR_W-1:0] LAYER_STRIDE = ADDR_W'((MAX_NEURONS + 1) * MAX_NEURONS);

    t_state r_state, n_state;

    logic [LCNT_W-1:0] r_layer, r_nl;
    logic [ADDR_W-1:0] r_base;
    logic [CNT_W-1:0]  r_prev, r_cur, r_t;
    logic [NIDX_W-1:0] r_j;
    logic              r_sel;
    logic signed [VW-1:0] r_feat [MAX_NEURONS];
    logic signed [VW-1:0] r_act [2][MAX_NEURONS];
    logic signed [VW-1:0] r_src_d;
    logic              r_bias_d, r_rd_v;
    logic signed [PROD_W-1:0] r_prod;
    logic              r_prod_v;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [VW-1:0] r_q;
    logic              r_sat;
    logic              r_valid;
    logic signed [15:0] r_pred;
    logic              r_out_sat;

    // control decode
    logic start, feat_we, issue, is_out;

    // datapath
    logic [CNT_W-1:0]  row;
    logic [NIDX_W-1:0] src_idx;
    logic signed [VW-1:0] src_val;
    logic signed [PROD_W-1:0] mul, bias_p;
    logic signed [ACC_W:0] sum, acc_clip, rnd, shr;
    logic              acc_flag;
    logic signed [VW-1:0] q_clip;
    logic              q_flag;
    logic signed [VW:0] sidx;
    logic [7:0]        rom_idx;
    logic [SIG_W-1:0]  rom_val;
    logic signed [VW-1:0] act_val;
    logic              act_flag;
    logic signed [15:0] pred_val;
    logic              pred_flag;
    logic [LCNT_W-1:0] start_nl, lnext;
    logic [CNT_W-1:0]  start_cur, next_cur;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (start) n_state = ST_MAC;
            ST_MAC:   if (r_t == r_prev) n_state = ST_DRAIN;
            ST_DRAIN: if (!r_rd_v && !r_prod_v) n_state = ST_ROUND;
            ST_ROUND: n_state = ST_ACT;
            ST_ACT:   n_state = is_out ? ST_IDLE : ST_MAC;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop    = (r_state == ST_IDLE) && !i_empty;
        o_ram_we = o_pop && i_head_ctl.is_weight;
        start    = o_pop && !i_head_ctl.is_weight && i_head_ctl.last;
        feat_we  = o_pop && !i_head_ctl.is_weight && i_head_ctl.store_feat;
        issue    = (r_state == ST_MAC);
    end

    assign is_out = (LCNT_W'(r_layer + 1'b1) == r_nl);

    // term zero is the bias row, then the previous activations (the features in layer zero) in order
    assign row         = (r_t == '0) ? r_prev : r_t - 1'b1;
    assign o_ram_raddr = r_base + ADDR_W'(row) * ADDR_W'(MAX_NEURONS) + ADDR_W'(r_j);
    assign src_idx     = NIDX_W'(r_t - 1'b1);
    assign src_val     = (r_layer == '0) ? r_feat[src_idx] : r_act[~r_sel][src_idx];

    assign mul    = i_ram_rdata * r_src_d;
    assign bias_p = i_ram_rdata <<< 8;
    assign sum    = r_acc + r_prod;

    always_comb begin
        acc_flag = 1'b0;
        acc_clip = sum;
        if (sum > ACC_MAX) begin
            acc_clip = ACC_MAX;
            acc_flag = 1'b1;
        end else if (sum < ACC_MIN) begin
            acc_clip = ACC_MIN;
            acc_flag = 1'b1;
        end
    end

    // round half up to Q.8 and clip to the value range
    assign rnd = r_acc + 128;
    assign shr = rnd >>> 8;

    always_comb begin
        q_flag = 1'b0;
        q_clip = VW'(shr);
        if (shr > VMAX) begin
            q_clip = VW'(VMAX);
            q_flag = 1'b1;
        end else if (shr < VMIN) begin
            q_clip = VW'(VMIN);
            q_flag = 1'b1;
        end
    end

    assign sidx = (VW + 1)'((r_q >>> 4) + 128);

    always_comb begin
        if (sidx < 0) rom_idx = 8'd0;
        else if (sidx > 255) rom_idx = 8'd255;
        else rom_idx = 8'(sidx);
        rom_val  = SIG_ROM[rom_idx];
        act_flag = 1'b0;
        if (i_cfg.act_kind == ACT_RELU) begin
            act_val = (r_q < 0) ? '0 : r_q;
        end else if (longint'(rom_val) > VMAX) begin
            act_val  = VW'(VMAX);
            act_flag = 1'b1;
        end else begin
            act_val = VW'(rom_val);
        end
    end

    always_comb begin
        pred_flag = 1'b0;
        pred_val  = 16'(r_q);
        if (longint'(r_q) > 32767) begin
            pred_val  = 16'sh7FFF;
            pred_flag = 1'b1;
        end else if (longint'(r_q) < -32768) begin
            pred_val  = 16'sh8000;
            pred_flag = 1'b1;
        end
    end

    // layer geometry at start and at each layer change
    always_comb begin
        if (i_cfg.layer_count == '0) start_nl = LCNT_W'(1);
        else if (32'(i_cfg.layer_count) > MAX_WEIGHT_LAYERS) start_nl = LCNT_W'(MAX_WEIGHT_LAYERS);
        else start_nl = LCNT_W'(i_cfg.layer_count);
        start_cur = (start_nl == LCNT_W'(1)) ? CNT_W'(1)
                  : CNT_W'(eff_size(i_cfg.hidden_one_size, MAX_NEURONS));
        lnext = LCNT_W'(r_layer + 1'b1);
        if (LCNT_W'(lnext + 1'b1) == r_nl) next_cur = CNT_W'(1);
        else if (lnext == LCNT_W'(1)) next_cur = CNT_W'(eff_size(i_cfg.hidden_two_size, MAX_NEURONS));
        else next_cur = CNT_W'(eff_size(i_cfg.hidden_three_size, MAX_NEURONS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_v   <= 1'b0;
            r_prod_v <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_v   <= issue;
            r_prod_v <= r_rd_v;
            r_valid  <= (r_state == ST_ACT) && is_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (feat_we) begin
            r_feat[i_head_fidx] <= i_head_val;
        end
        r_src_d  <= src_val;
        r_bias_d <= (r_t == '0);
        r_prod   <= r_bias_d ? bias_p : mul;
        if (r_prod_v) begin
            r_acc <= ACC_W'(acc_clip);
            if (acc_flag) r_sat <= 1'b1;
        end
        if (issue && (r_t != r_prev)) begin
            r_t <= r_t + 1'b1;
        end
        if (start) begin
            r_layer <= '0;
            r_nl    <= start_nl;
            r_base  <= '0;
            r_prev  <= CNT_W'(eff_size(i_cfg.input_size, MAX_NEURONS));
            r_cur   <= start_cur;
            r_j     <= '0;
            r_t     <= '0;
            r_sel   <= 1'b0;
            r_acc   <= '0;
            r_sat   <= 1'b0;
        end
        if (r_state == ST_ROUND) begin
            r_q <= q_clip;
            if (q_flag) r_sat <= 1'b1;
        end
        if (r_state == ST_ACT) begin
            r_t   <= '0;
            r_acc <= '0;
            if (is_out) begin
                r_pred    <= pred_val;
                r_out_sat <= r_sat || pred_flag;
            end else begin
                r_act[r_sel][r_j] <= act_val;
                if (act_flag) r_sat <= 1'b1;
                if (CNT_W'(r_j) + 1'b1 == r_cur) begin
                    r_layer <= lnext;
                    r_base  <= r_base + LAYER_STRIDE;
                    r_prev  <= r_cur;
                    r_cur   <= next_cur;
                    r_j     <= '0;
                    r_sel   <= ~r_sel;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_prediction = r_pred;
    assign o_saturated  = r_out_sat;
endmodule

// ===== hw/rtl/mfi_checker.sv =====
// port-level checks for the mlp inference block, bound to the top level
// depends on assert_macros.svh and mfi_pkg
`include "assert_macros.svh"
module mfi_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_start,
    input logic                           o_busy,
    input logic                           i_kind,
    input logic [1:0]                     i_layer_index,
    input logic [4:0]                     i_row_index,
    input logic [3:0]                     i_column_index,
    input logic signed [15:0]             i_value,
    input logic                           i_last_feature,
    input logic                           i_cfg_we,
    input logic [mfi_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input logic [mfi_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input logic                           o_valid,
    input logic signed [15:0]             o_prediction,
    input logic                           o_saturated
);
    // the sequencer goes back through idle and a whole pass between results, so results never come back to back
    `MFI_ASSERT(a_strobe_single, o_valid |=> !o_valid, "result strobe longer than one cycle")
    `MFI_ASSERT_RST(a_reset_quiet, !i_rst_n |=> (!o_valid && !o_busy), "outputs active after reset")
    `MFI_ASSERT(a_result_known, o_valid |-> !$isunknown(o_prediction), "result prediction unknown")
    // the queue only fills from an accepted request
    `MFI_ASSERT(a_busy_from_request, $rose(o_busy) |-> $past(i_start), "busy without request")
endmodule

bind mlp_forward_inference mfi_checker u_checker (.*);

// ===== verif/mlp_forward_inference_test.sv =====
// self-checking testbench of mlp_forward_inference: a directed table, then random samples
// over several layer setups, checked against table values or a fixed-point network predictor
// depends on mfi_pkg and mlp_forward_inference
module mlp_forward_inference_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mfi_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int ROWS = 17;
    localparam int SETTLE_CYCLES = 2500;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        bit                 kind;
        bit [1:0]           layer;
        bit [4:0]           row;
        bit [3:0]           col;
        logic signed [15:0] value;
        bit                 last;
        bit                 has_exp;
        logic signed [15:0] exp_pred;
        bit                 exp_sat;
    } t_request;

    typedef struct {
        logic signed [15:0] pred;
        bit                 sat;
    } t_answer;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic               i_kind;
    logic [1:0]         i_layer_index;
    logic [4:0]         i_row_index;
    logic [3:0]         i_column_index;
    logic signed [15:0] i_value;
    logic               i_last_feature;
    logic               i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic               o_valid;
    logic signed [15:0] o_prediction;
    logic               o_saturated;

    mlp_forward_inference DUT (.*);

    // predictor state
    logic signed [15:0] weight_mem [0:4*ROWS*16-1];
    logic signed [15:0] feat_mem [0:15];
    int unsigned        sig_lut [0:255];
    t_act               act_kind;
    bit [2:0]           layer_count;
    bit [4:0]           in_size, h1_size, h2_size, h3_size;

    t_answer answer_q [$];
    int      errors;
    int      idle_pct;
    longint  cycles;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_answer a;
        if (i_rst_n && o_valid) begin
            if (answer_q.size() == 0) begin
                $display("%0t: unexpected result pred=%h sat=%b", $time, o_prediction,
                         o_saturated);
                errors++;
            end else begin
                a = answer_q.pop_front();
                if (o_prediction !== a.pred) begin
                    $display("%0t: prediction expected %h actual %h", $time, a.pred,
                             o_prediction);
                    errors++;
                end
                if (o_saturated !== a.sat) begin
                    $display("%0t: saturated expected %b actual %b", $time, a.sat,
                             o_saturated);
                    errors++;
                end
            end
        end
    end

    function automatic int eff_sz(bit [4:0] r);
        if (r == 0) return 1;
        return (r > 16) ? 16 : int'(r);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi, ref bit flag);
        if (v < lo) begin
            flag = 1;
            return lo;
        end
        if (v > hi) begin
            flag = 1;
            return hi;
        end
        return v;
    endfunction

    task automatic build_sigmoid();
        longint unsigned e, den;
        e = 64'd1 << 32;
        for (int m = 0; m <= 128; m++) begin
            den = (64'd1 << 32) + e;
            if (m < 128) sig_lut[128 + m] = 32'(((64'd1 << 40) + den / 2) / den);
            if (m >= 1) sig_lut[128 - m] = 32'((e * 256 + den / 2) / den);
            e = (e * 64'd4034748382 + (64'd1 << 31)) >> 32;
        end
    endtask

    // one forward pass of the network over the feature buffer
    task automatic forward_pass(output t_answer ans);
        longint src [16];
        longint dst [16];
        longint acc, q, idx;
        longint acc_max;
        int nl, prv, cur;
        bit sat;
        acc_max = (64'sd1 <<< 62) - 1;
        sat = 0;
        ans.pred = '0;
        nl = (layer_count == 0) ? 1 : ((layer_count > 4) ? 4 : int'(layer_count));
        prv = eff_sz(in_size);
        for (int i = 0; i < 16; i++) src[i] = feat_mem[i];
        for (int l = 0; l < nl; l++) begin
            cur = (l + 1 == nl) ? 1 :
                  (l == 0) ? eff_sz(h1_size) : (l == 1) ? eff_sz(h2_size) : eff_sz(h3_size);
            for (int j = 0; j < cur; j++) begin
                acc = longint'(weight_mem[(l * ROWS + prv) * 16 + j]) * 256;
                for (int i = 0; i < prv; i++) begin
                    acc += src[i] * longint'(weight_mem[(l * ROWS + i) * 16 + j]);
                    acc = clip(acc, -acc_max, acc_max, sat);
                end
                q = clip((acc + 128) >>> 8, -32768, 32767, sat);
                if (l + 1 == nl) begin
                    ans.pred = q[15:0];
                end else begin
                    if (act_kind == ACT_RELU) begin
                        if (q < 0) q = 0;
                    end else begin
                        idx = (q >>> 4) + 128;
                        if (idx < 0) idx = 0;
                        if (idx > 255) idx = 255;
                        q = sig_lut[idx];
                    end
                    dst[j] = q;
                end
            end
            prv = cur;
            src = dst;
        end
        ans.sat = sat;
    endtask

    // update the predictor with an accepted request
    task automatic take_request(t_request r);
        t_answer a;
        if (r.kind == 1'b0) begin
            if (r.row <= 16) weight_mem[(r.layer * ROWS + r.row) * 16 + r.col] = r.value;
            return;
        end
        if (r.row < eff_sz(in_size)) feat_mem[r.row] = r.value;
        if (!r.last) return;
        forward_pass(a);
        if (r.has_exp) begin
            a.pred = r.exp_pred;
            a.sat = r.exp_sat;
        end
        answer_q = {answer_q, a};
    endtask

    // called right after a rising edge; each cycle the sender may idle
    task automatic send(t_request r);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start        <= 1'b1;
        i_kind         <= r.kind;
        i_layer_index  <= r.layer;
        i_row_index    <= r.row;
        i_column_index <= r.col;
        i_value        <= r.value;
        i_last_feature <= r.last;
        do @(posedge i_clk); while (o_busy);
        take_request(r);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [4:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_ACT_KIND:     act_kind = t_act'(val[0]);
            CFG_LAYER_COUNT:  layer_count = val[2:0];
            CFG_INPUT_SIZE:   in_size = val;
            CFG_HIDDEN_ONE:   h1_size = val;
            CFG_HIDDEN_TWO:   h2_size = val;
            CFG_HIDDEN_THREE: h3_size = val;
            default: ;
        endcase
    endtask

    task automatic set_network(bit ak, bit [2:0] nl, bit [4:0] a, bit [4:0] b, bit [4:0] c,
                               bit [4:0] d);
        write_reg(CFG_ACT_KIND, 5'(ak));
        write_reg(CFG_LAYER_COUNT, 5'(nl));
        write_reg(CFG_INPUT_SIZE, a);
        write_reg(CFG_HIDDEN_ONE, b);
        write_reg(CFG_HIDDEN_TWO, c);
        write_reg(CFG_HIDDEN_THREE, d);
    endtask

    function automatic logic signed [15:0] rand_value();
        if ($urandom_range(99) < 70) return 16'($urandom_range(0, 1023)) - 16'sd512;
        return 16'($urandom);
    endfunction

    function automatic t_request mk(bit kind, bit [1:0] layer, bit [4:0] row, bit [3:0] col,
                                    logic signed [15:0] value, bit last);
        t_request r;
        r = '{kind, layer, row, col, value, last, 1'b0, 16'sd0, 1'b0};
        return r;
    endfunction

    // mostly full samples with fresh weights mixed in, some stray requests
    task automatic random_phase(int n_items);
        int sent, isz;
        int order [16];
        int k, tmp;
        sent = 0;
        isz = eff_sz(in_size);
        while (sent < n_items) begin
            if ($urandom_range(99) < 80) begin
                repeat ($urandom_range(0, 4)) begin
                    send(mk(1'b0, 2'($urandom_range(0, 3)), 5'($urandom_range(0, 16)),
                            4'($urandom), rand_value(), 1'b0));
                    sent++;
                end
                for (int i = 0; i < isz; i++) order[i] = i;
                for (int i = isz - 1; i > 0; i--) begin
                    k = $urandom_range(0, i);
                    tmp = order[i];
                    order[i] = order[k];
                    order[k] = tmp;
                end
                for (int i = 0; i < isz; i++) begin
                    send(mk(1'b1, 2'($urandom), 5'(order[i]), 4'($urandom), rand_value(),
                            i == isz - 1));
                    sent++;
                end
            end else begin
                case ($urandom_range(0, 2))
                    0: send(mk(1'b0, 2'($urandom), 5'($urandom_range(17, 31)), 4'($urandom),
                               16'($urandom), 1'($urandom)));
                    1: send(mk(1'b0, 2'($urandom), 5'($urandom_range(0, 16)), 4'($urandom),
                               rand_value(), 1'b1));
                    default: send(mk(1'b1, 2'($urandom), 5'($urandom_range(isz, 31)),
                                     4'($urandom), 16'($urandom), 1'($urandom)));
                endcase
                sent++;
            end
        end
    endtask

    // single layer, single input: prediction = feature * weight + bias
    t_request dir_table [] = '{
        '{0, 0, 0, 0, 16'sh0100, 0, 0, 16'sh0000, 0},
        '{0, 0, 1, 0, 16'sh0000, 0, 0, 16'sh0000, 0},
        '{1, 0, 0, 0, 16'sh7fff, 1, 1, 16'sh7fff, 0},
        '{1, 0, 0, 0, 16'sh8000, 1, 1, 16'sh8000, 0},
        '{1, 3, 0, 15, 16'sh0000, 1, 1, 16'sh0000, 0},
        '{0, 0, 1, 0, 16'sh7fff, 0, 0, 16'sh0000, 0},
        '{1, 0, 0, 0, 16'sh7fff, 1, 1, 16'sh7fff, 1},
        '{0, 0, 1, 0, 16'sh8000, 0, 0, 16'sh0000, 0},
        '{1, 0, 0, 0, 16'sh8000, 1, 1, 16'sh8000, 1},
        '{0, 0, 1, 0, 16'sh0080, 0, 0, 16'sh0000, 0},
        '{1, 0, 0, 0, 16'sh0000, 1, 1, 16'sh0080, 0},
        // weight write with last set gives nothing
        '{0, 0, 1, 0, 16'sh0000, 1, 0, 16'sh0000, 0},
        // row past the bias row is dropped
        '{0, 3, 31, 15, 16'sh5555, 0, 0, 16'sh0000, 0},
        // feature past the input size is dropped but still starts the pass
        '{1, 0, 5, 0, 16'sh1234, 1, 1, 16'sh0000, 0},
        '{1, 0, 0, 0, 16'sh0001, 1, 1, 16'sh0001, 0},
        '{0, 0, 0, 0, 16'shffff, 0, 0, 16'sh0000, 0},
        '{1, 0, 0, 0, 16'sh7fff, 1, 0, 16'sh0000, 0},
        '{0, 0, 1, 0, 16'shc000, 0, 0, 16'sh0000, 0},
        '{1, 2, 16, 8, 16'sh8001, 1, 0, 16'sh0000, 0},
        '{0, 1, 16, 15, 16'sh2aaa, 0, 0, 16'sh0000, 0},
        '{0, 2, 16, 0, 16'shd555, 0, 0, 16'sh0000, 0}
    };

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_kind = 1'b0;
        i_layer_index = '0;
        i_row_index = '0;
        i_column_index = '0;
        i_value = '0;
        i_last_feature = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        errors = 0;
        cycles = 0;
        idle_pct = 21;
        act_kind = ACT_RELU;
        layer_count = 3'd2;
        in_size = 5'd16;
        h1_size = 5'd16;
        h2_size = 5'd16;
        h3_size = 5'd16;
        build_sigmoid();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every weight and feature that a pass can read gets written first
        for (int l = 0; l < 3; l++)
            for (int r = 0; r < ROWS; r++)
                for (int c = 0; c < 16; c++)
                    send(mk(1'b0, 2'(l), 5'(r), 4'(c), rand_value(), 1'b0));
        // the fourth layer is only ever the single output neuron
        for (int r = 0; r < ROWS; r++)
            send(mk(1'b0, 2'd3, 5'(r), 4'd0, rand_value(), 1'b0));
        for (int i = 0; i < 16; i++)
            send(mk(1'b1, 2'd0, 5'(i), 4'd0, rand_value(), 1'b0));
        drain();

        set_network(1'b0, 3'd1, 5'd1, 5'd16, 5'd16, 5'd16);
        write_reg(CFG_SPARE_LO, 5'd31);
        write_reg(CFG_SPARE_HI, 5'd0);
        foreach (dir_table[i]) send(dir_table[i]);
        random_phase(20);

        for (int ph = 1; ph <= 8; ph++) begin
            drain();
            idle_pct = (ph <= 3) ? 21 : (ph <= 6) ? 72 : 0;
            case (ph)
                1: set_network(1'b0, 3'd2, 5'd16, 5'd16, 5'd16, 5'd16);
                2: set_network(1'b1, 3'd4, 5'd16, 5'd16, 5'd16, 5'd16);
                3: set_network(1'b1, 3'd0, 5'd0, 5'd0, 5'd0, 5'd0);
                4: set_network(1'b0, 3'd7, 5'd31, 5'd1, 5'd1, 5'd1);
                5: set_network(1'b1, 3'd3, 5'd5, 5'd31, 5'd3, 5'd0);
                6: set_network(1'b0, 3'd4, 5'd3, 5'd2, 5'd7, 5'd9);
                default: set_network(1'($urandom), 3'($urandom), 5'($urandom_range(0, 8)),
                                     5'($urandom_range(0, 8)), 5'($urandom_range(0, 8)),
                                     5'($urandom_range(0, 8)));
            endcase
            random_phase(15);
        end

        drain();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
